// ===== hdl/chd_pkg.sv =====
// Shared types, constants and helper functions for the chunked body decoder.
package chd_pkg;

  localparam int SIZE_BITS_DEFAULT = 32;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       body_start;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] payload_byte;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_value(input logic [7:0] b);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      h.value = 4'(b - CH_ZERO);
    end else if (b >= CH_LO_A && b <= CH_LO_F) begin
      h.value = 4'(b - CH_LO_A + 8'd10);
    end else if (b >= CH_UP_A && b <= CH_UP_F) begin
      h.value = 4'(b - CH_UP_A + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

endpackage

// ===== hdl/chd_in_stage.sv =====
// Input register holding one body item ahead of the decode step.
module chd_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          body_valid,
  output logic          body_ready,
  input  logic [7:0]    body_byte,
  input  logic          body_start,
  input  logic          take,
  output logic          held_valid,
  output chd_pkg::item_t held
);
  import chd_pkg::*;

  logic  held_valid_r;
  item_t held_r;

  assign body_ready = !held_valid_r || take;
  assign held_valid = held_valid_r;
  assign held       = held_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid_r <= 1'b0;
    end else if (body_ready) begin
      held_valid_r <= body_valid;
    end
    if (body_valid && body_ready) begin
      held_r.body_byte  <= body_byte;
      held_r.body_start <= body_start;
    end
  end

endmodule

// ===== hdl/chd_core.sv =====
// Chunk framing state machine: one byte per step, at most one result.
module chd_core #(
  parameter int SIZE_BITS = chd_pkg::SIZE_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  chd_pkg::item_t   item,
  output chd_pkg::result_t res
);
  import chd_pkg::*;

  typedef enum logic [3:0] {
    PH_SKIPWS,
    PH_AFTER_ZERO,
    PH_PREFIX_X,
    PH_DIGITS,
    PH_EXT,
    PH_DATA,
    PH_TRAIL_CR,
    PH_TRAIL_LF,
    PH_DONE
  } phase_t;

  phase_t               phase, phase_next;
  logic [SIZE_BITS-1:0] remaining, remaining_next;
  logic [SIZE_BITS-1:0] size_value, size_value_next;
  logic                 saw_cr, saw_cr_next;

  always_comb begin
    logic [7:0] b;
    hex_t       h;
    logic       line, do_digit, do_rest, do_fail;
    b        = item.body_byte;
    h        = hex_value(b);
    line     = 1'b0;
    do_digit = 1'b0;
    do_rest  = 1'b0;
    do_fail  = 1'b0;
    res.valid        = 1'b0;
    res.kind         = KIND_DATA;
    res.payload_byte = 8'd0;

    phase_next      = phase;
    remaining_next  = remaining;
    size_value_next = size_value;
    saw_cr_next     = saw_cr;

    if (item.body_start) begin
      phase_next      = PH_SKIPWS;
      remaining_next  = '0;
      size_value_next = '0;
      saw_cr_next     = 1'b0;
    end

    case (phase_next)
      PH_SKIPWS, PH_AFTER_ZERO, PH_PREFIX_X, PH_DIGITS, PH_EXT: begin
        line = 1'b1;
      end
      PH_DATA: begin
        if (remaining_next != '0) remaining_next = remaining_next - 1'b1;
        if (remaining_next == '0) phase_next = PH_TRAIL_CR;
        res.valid        = 1'b1;
        res.kind         = KIND_DATA;
        res.payload_byte = b;
      end
      PH_TRAIL_CR: begin
        if (b == CH_CR) begin
          phase_next = PH_TRAIL_LF;
        end else begin
          phase_next      = PH_SKIPWS;
          size_value_next = '0;
          saw_cr_next     = 1'b0;
          line            = 1'b1;
        end
      end
      PH_TRAIL_LF: begin
        phase_next      = PH_SKIPWS;
        size_value_next = '0;
        if (b == CH_LF) begin
          saw_cr_next = 1'b0;
        end else begin
          saw_cr_next = 1'b1;
          line        = 1'b1;
        end
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase

    if (line) begin
      case (phase_next)
        PH_SKIPWS: begin
          if (saw_cr_next && b == CH_LF) begin
            do_fail = 1'b1;
          end else if (is_space(b)) begin
            saw_cr_next = (b == CH_CR);
          end else begin
            saw_cr_next = 1'b0;
            if (b == CH_ZERO) begin
              size_value_next = '0;
              phase_next      = PH_AFTER_ZERO;
            end else if (h.ok) begin
              do_digit = 1'b1;
            end else begin
              do_fail = 1'b1;
            end
          end
        end
        PH_AFTER_ZERO: begin
          if (b == CH_LO_X || b == CH_UP_X) phase_next = PH_PREFIX_X;
          else if (h.ok) do_digit = 1'b1;
          else do_rest = 1'b1;
        end
        PH_PREFIX_X, PH_DIGITS: begin
          if (h.ok) do_digit = 1'b1;
          else do_rest = 1'b1;
        end
        default: begin
          do_rest = 1'b1;
        end
      endcase

      if (do_digit) begin
        if (size_value_next[SIZE_BITS-1 -: 4] != 4'd0) begin
          do_fail = 1'b1;
        end else begin
          size_value_next = {size_value_next[SIZE_BITS-5:0], h.value};
          phase_next      = PH_DIGITS;
        end
      end

      if (do_rest) begin
        phase_next = PH_EXT;
        if (saw_cr_next && b == CH_LF) begin
          saw_cr_next = 1'b0;
          if (size_value_next == '0) begin
            phase_next = PH_DONE;
            res.valid  = 1'b1;
            res.kind   = KIND_END;
          end else begin
            remaining_next = size_value_next;
            phase_next     = PH_DATA;
          end
        end else begin
          saw_cr_next = (b == CH_CR);
        end
      end

      if (do_fail) begin
        phase_next = PH_DONE;
        res.valid  = 1'b1;
        res.kind   = KIND_ERROR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SKIPWS;
      remaining  <= '0;
      size_value <= '0;
      saw_cr     <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      remaining  <= remaining_next;
      size_value <= size_value_next;
      saw_cr     <= saw_cr_next;
    end
  end

endmodule

// ===== hdl/chd_out_stage.sv =====
// Result register on the output channel.
module chd_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  chd_pkg::result_t res,
  output logic             free,
  output logic             result_valid,
  input  logic             result_ready,
  output logic [7:0]       payload_byte,
  output logic [1:0]       kind
);
  import chd_pkg::*;

  logic       full;
  logic [7:0] byte_r;
  logic [1:0] kind_r;

  assign free         = !full || result_ready;
  assign result_valid = full;
  assign payload_byte = byte_r;
  assign kind         = kind_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (free) begin
      full <= load && res.valid;
    end
    if (free && load && res.valid) begin
      byte_r <= res.payload_byte;
      kind_r <= res.kind;
    end
  end

endmodule

// ===== hdl/http_chunked_body_decoder.sv =====
// Top level of the HTTP chunked body decoder.
//   channel  signals                              dir  payload
//   body     body_valid/body_ready                in   body_byte[7:0], body_start
//   result   result_valid/result_ready            out  payload_byte[7:0], kind[1:0]
// One item per cycle sustained while the result channel is not stalled; an item's result
// passes through the input register, then the decode step into the result register.
// Each item updates the framing state in a single step: one SIZE_BITS decrement
// and compare set the cycle.
// rst (synchronous) returns to the start of a size line with empty counters.
// A stalled result holds the decode step; the input register then fills and
// body_ready drops.
module http_chunked_body_decoder #(
  parameter int SIZE_BITS = chd_pkg::SIZE_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       body_valid,
  output logic       body_ready,
  input  logic [7:0] body_byte,
  input  logic       body_start,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [7:0] payload_byte,
  output logic [1:0] kind
);
  import chd_pkg::*;

  logic    held_valid;
  item_t   held;
  logic    out_free;
  logic    step;
  result_t res;

  assign step = held_valid && out_free;

  chd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .body_valid (body_valid),
    .body_ready (body_ready),
    .body_byte  (body_byte),
    .body_start (body_start),
    .take       (step),
    .held_valid (held_valid),
    .held       (held)
  );

  chd_core #(
    .SIZE_BITS (SIZE_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (held),
    .res  (res)
  );

  chd_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (step),
    .res          (res),
    .free         (out_free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .payload_byte (payload_byte),
    .kind         (kind)
  );

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (kind == KIND_DATA || kind == KIND_END || kind == KIND_ERROR))
    else $error("illegal result kind");

  a_stop_no_byte: assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind != KIND_DATA) |-> payload_byte == 8'd0)
    else $error("end or error carries a byte");

  a_held_kept: assert property (@(posedge clk) disable iff (rst)
    (held_valid && !out_free) |=> held_valid && $stable(held))
    else $error("held item lost while output stalled");

endmodule

// ===== tb/http_chunked_body_decoder_tb.sv =====
// Testbench for the chunked body decoder: framed random bodies checked by a byte-level predictor.
module http_chunked_body_decoder_tb;
  import chd_pkg::*;

  localparam int SIZE_W = SIZE_BITS_DEFAULT;
  localparam int ITEM_TARGET = 900;
  localparam int IDLE_LIMIT = 1000;

  typedef enum logic [3:0] {
    SKIP_WS, AFTER_ZERO, PREFIX_X, SIZE_DIGITS, LINE_EXT,
    CHUNK_DATA, TRAIL_CR, TRAIL_LF, STOPPED
  } framing_e;

  typedef struct packed {
    logic [7:0] pbyte;
    logic [1:0] kind;
  } decoded_t;

  class chunk_checker;
    framing_e phase;
    logic [SIZE_W-1:0] left;
    logic [SIZE_W-1:0] size_acc;
    logic cr_seen;
    decoded_t decoded_q[$];
    int errors;
    int seen;

    function new();
      clear();
      errors = 0;
      seen = 0;
    endfunction

    function void restart_line();
      phase = SKIP_WS;
      size_acc = '0;
      cr_seen = 1'b0;
    endfunction

    function void clear();
      restart_line();
      left = '0;
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction

    function void push(logic [1:0] k, logic [7:0] b);
      decoded_t d;
      d.pbyte = b;
      d.kind = k;
      decoded_q.push_back(d);
    endfunction

    function bit is_blank(logic [7:0] b);
      return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function bit is_hex(logic [7:0] b);
      return (b >= CH_ZERO && b <= CH_NINE) || (b >= CH_LO_A && b <= CH_LO_F) ||
             (b >= CH_UP_A && b <= CH_UP_F);
    endfunction

    function logic [3:0] hex_of(logic [7:0] b);
      logic [7:0] v;
      if (b <= CH_NINE) v = b - CH_ZERO;
      else if (b >= CH_LO_A) v = b - CH_LO_A + 8'd10;
      else v = b - CH_UP_A + 8'd10;
      return v[3:0];
    endfunction

    function void stop_on_error();
      phase = STOPPED;
      push(KIND_ERROR, 8'h00);
    endfunction

    function void take_digit(logic [3:0] v);
      if (size_acc[SIZE_W-1 -: 4] != 4'd0) begin
        stop_on_error();
      end else begin
        size_acc = {size_acc[SIZE_W-5:0], v};
        phase = SIZE_DIGITS;
      end
    endfunction

    // Rest of the size line: only CR LF matters.
    function void line_tail(logic [7:0] b);
      phase = LINE_EXT;
      if (cr_seen && b == CH_LF) begin
        cr_seen = 1'b0;
        if (size_acc == '0) begin
          phase = STOPPED;
          push(KIND_END, 8'h00);
        end else begin
          left = size_acc;
          phase = CHUNK_DATA;
        end
      end else begin
        cr_seen = (b == CH_CR);
      end
    endfunction

    function void line_byte(logic [7:0] b);
      case (phase)
        SKIP_WS: begin
          if (cr_seen && b == CH_LF) begin
            stop_on_error();
          end else if (is_blank(b)) begin
            cr_seen = (b == CH_CR);
          end else begin
            cr_seen = 1'b0;
            if (b == CH_ZERO) begin
              size_acc = '0;
              phase = AFTER_ZERO;
            end else if (is_hex(b)) begin
              take_digit(hex_of(b));
            end else begin
              stop_on_error();
            end
          end
        end
        AFTER_ZERO: begin
          if (b == CH_LO_X || b == CH_UP_X) phase = PREFIX_X;
          else if (is_hex(b)) take_digit(hex_of(b));
          else line_tail(b);
        end
        PREFIX_X, SIZE_DIGITS: begin
          if (is_hex(b)) take_digit(hex_of(b));
          else line_tail(b);
        end
        default: line_tail(b);
      endcase
    endfunction

    function void note_input(logic [7:0] b, logic start);
      if (start) clear();
      case (phase)
        CHUNK_DATA: begin
          if (left != '0) left--;
          if (left == '0) phase = TRAIL_CR;
          push(KIND_DATA, b);
        end
        TRAIL_CR: begin
          if (b == CH_CR) begin
            phase = TRAIL_LF;
          end else begin
            restart_line();
            line_byte(b);
          end
        end
        TRAIL_LF: begin
          restart_line();
          if (b != CH_LF) begin
            cr_seen = 1'b1;
            line_byte(b);
          end
        end
        STOPPED: ;
        default: line_byte(b);
      endcase
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [7:0] pb, logic [1:0] k);
      decoded_t want;
      if (decoded_q.size() == 0) begin
        report($sformatf("result %0d kind %0d byte %02h with nothing expected", seen, k, pb));
      end else begin
        want = decoded_q.pop_front();
        if (k !== want.kind)
          report($sformatf("result %0d kind %0d, expected %0d", seen, k, want.kind));
        if (pb !== want.pbyte)
          report($sformatf("result %0d byte %02h, expected %02h", seen, pb, want.pbyte));
      end
      seen++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic body_valid = 1'b0;
  logic body_ready;
  logic [7:0] body_byte = 8'h00;
  logic body_start = 1'b0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic [7:0] payload_byte;
  logic [1:0] kind;

  chunk_checker sb = new();
  logic [7:0] frame_q[$];
  bit src_calm = 1'b0;
  bit snk_calm = 1'b0;
  int fed = 0;
  int idle_cycles = 0;

  http_chunked_body_decoder u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int draw_wait(bit calm);
    if (calm || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(1, 12);
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (body_valid && body_ready) sb.note_input(body_byte, body_start);
      if (result_valid && result_ready) sb.check_result(payload_byte, kind);
      if ((body_valid && body_ready) || (result_valid && result_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int stall;
    forever begin
      if ($urandom_range(0, 49) == 0) snk_calm = !snk_calm;
      stall = draw_wait(snk_calm);
      @(negedge clk);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
    end
  end

  task automatic send_item(logic [7:0] b, logic s);
    int gap;
    gap = draw_wait(src_calm);
    @(negedge clk);
    if (gap > 0) begin
      body_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    body_valid <= 1'b1;
    body_byte <= b;
    body_start <= s;
    do @(posedge clk); while (!body_ready);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) send_item(frame_q[i], i == 0);
    frame_q.delete();
  endtask

  function automatic void put_byte(logic [7:0] b);
    frame_q.push_back(b);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
  endfunction

  function automatic void put_crlf();
    put_byte(CH_CR);
    put_byte(CH_LF);
  endfunction

  function automatic void put_blank();
    case ($urandom_range(0, 5))
      0: put_byte(CH_SPACE);
      1: put_byte(CH_TAB);
      2: put_byte(8'h0B);
      3: put_byte(8'h0C);
      4: put_byte(CH_LF);
      default: begin
        put_byte(CH_CR);
        put_byte(CH_SPACE);
      end
    endcase
  endfunction

  function automatic void put_hex(logic [SIZE_W-1:0] v);
    int top;
    logic [3:0] nib;
    top = SIZE_W / 4 - 1;
    while (top > 0 && v[top*4 +: 4] == 4'd0) top--;
    if (top < SIZE_W / 4 - 1 && $urandom_range(0, 4) == 0) top++;
    for (int n = top; n >= 0; n--) begin
      nib = v[n*4 +: 4];
      if (nib < 4'd10) put_byte(CH_ZERO + 8'(nib));
      else put_byte(($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + 8'(nib) - 8'd10);
    end
  endfunction

  function automatic void put_size_line(logic [SIZE_W-1:0] v);
    repeat ($urandom_range(0, 2)) put_blank();
    if ($urandom_range(0, 4) == 0) begin
      put_byte(CH_ZERO);
      put_byte($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
    end
    put_hex(v);
    if ($urandom_range(0, 3) == 0) put_text(";ext=q");
    put_crlf();
  endfunction

  function automatic void put_chunk();
    int sz;
    sz = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    put_size_line(SIZE_W'(sz));
    repeat (sz) put_byte(8'($urandom));
    case ($urandom_range(0, 7))
      6: ;
      7: put_byte(CH_CR);
      default: put_crlf();
    endcase
  endfunction

  function automatic void build_body();
    int shape;
    shape = $urandom_range(0, 9);
    if (shape <= 6) begin
      repeat ($urandom_range(1, 4)) put_chunk();
      put_size_line('0);
    end else if (shape == 7) begin
      repeat ($urandom_range(0, 2)) put_chunk();
      put_size_line(SIZE_W'($urandom));
      repeat ($urandom_range(0, 10)) put_byte(8'($urandom));
    end else if (shape == 8) begin
      repeat ($urandom_range(0, 2)) put_chunk();
      repeat ($urandom_range(0, 2)) put_blank();
      case ($urandom_range(0, 4))
        0: put_crlf();
        1: put_text("-1");
        2: put_text("+4");
        3: put_text("g");
        default: begin
          put_hex({1'b1, (SIZE_W-1)'($urandom)});
          put_hex(SIZE_W'($urandom_range(0, 15)));
        end
      endcase
    end else begin
      repeat ($urandom_range(1, 20)) put_byte(8'($urandom));
    end
    fed += frame_q.size();
    if (shape != 7) repeat ($urandom_range(0, 3)) put_byte(8'($urandom));
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    put_byte(CH_SPACE);
    put_byte(CH_TAB);
    put_text("1");
    put_crlf();
    put_byte(8'hFF);
    put_text("0X");
    put_crlf();
    send_frame();
    put_byte(CH_CR);
    put_crlf();
    send_frame();
    put_text("-5");
    send_frame();
    put_text("100000000");
    send_frame();

    while (fed < ITEM_TARGET) begin
      src_calm = ($urandom_range(0, 3) == 0);
      build_body();
      send_frame();
    end
    @(negedge clk) body_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
